// ----- rtl/bffa_pkg.sv -----
// shared constants, types and codes for the bitmap first-fit allocator
package bffa_pkg;

  localparam int POOL_UNITS = 256;
  localparam int UNIT_BYTES = 16;

  localparam int UNIT_W     = (POOL_UNITS > 2) ? $clog2(POOL_UNITS) : 1;
  localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
  localparam int BYTES_W    = 13;
  localparam int OFFSET_W   = 8;
  localparam int FRAG_W     = 32;
  localparam int REQ_UNITS_W = BYTES_W + 1 - UNIT_SHIFT;
  localparam int CNT_W      = (UNIT_W + 1 > REQ_UNITS_W) ? UNIT_W + 1 : REQ_UNITS_W;
  localparam int PAD_W      = CNT_W + UNIT_SHIFT;

  localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(POOL_UNITS);
  localparam logic [UNIT_W-1:0] LAST_UNIT = UNIT_W'(POOL_UNITS - 1);

  typedef enum logic [1:0] {
    MARK_FREE = 2'd0,
    MARK_HEAD = 2'd1,
    MARK_CONT = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_NOTHEAD = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_t;

  typedef struct packed {
    logic              we;
    logic [UNIT_W-1:0] waddr;
    mark_t             wdata;
    logic [UNIT_W-1:0] raddr;
  } mark_req_t;

endpackage

// ----- rtl/bffa_ifs.sv -----
// request and response channel interfaces of the allocator
interface bffa_req_if import bffa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [BYTES_W-1:0]  request_bytes;
  logic [OFFSET_W-1:0] block_offset;

  modport source (output valid, command, request_bytes, block_offset, input ready);
  modport sink (input valid, command, request_bytes, block_offset, output ready);
endinterface

interface bffa_rsp_if import bffa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [OFFSET_W-1:0] granted_offset;
  logic [FRAG_W-1:0]   frag_total;

  modport source (output valid, status, granted_offset, frag_total, input ready);
  modport sink (input valid, status, granted_offset, frag_total, output ready);
endinterface

// ----- rtl/bffa_mark_store.sv -----
// unit mark memory with its clearing sweep after reset
module bffa_mark_store import bffa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mark_req_t req,
  output mark_t     rd_data,
  output logic      clearing
);

  mark_t             mem [POOL_UNITS];
  logic [UNIT_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == LAST_UNIT) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + UNIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= MARK_FREE;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

// ----- rtl/bitmap_first_fit_allocator_unit.sv -----
// Bitmap first-fit pool allocator over POOL_UNITS units of 16 bytes, one
// request beat in, one response beat out. After reset a clearing pass marks
// every unit free; no request is taken until it ends.
// Every step walks the mark memory one unit per cycle through its one read
// port and one write port. An allocate scans for the first fitting run of
// free units, then marks each granted unit, then posts the response.
// A refused allocate (zero bytes or larger than the pool) goes straight to
// the response. A free checks that the unit is a head, then releases it and
// each continuation unit after it, stopping at the first unit that is not a
// continuation or at the end of the pool; a free of a unit that is not a
// head answers with ST_NOTHEAD.
// The response sits in an output register, so a new request is accepted while
// the previous response still waits to be taken.
module bitmap_first_fit_allocator_unit import bffa_pkg::*; (
  input logic    clk,
  input logic    rst,
  bffa_req_if.sink   req,
  bffa_rsp_if.source rsp
);

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_SCAN       = 6'b000010,
    S_MARK       = 6'b000100,
    S_FREE_CHECK = 6'b001000,
    S_FREE_WALK  = 6'b010000,
    S_RESP       = 6'b100000
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   units, units_next;
  logic [BYTES_W-1:0] bytes, bytes_next;
  logic [UNIT_W-1:0]  base, base_next;
  logic [UNIT_W-1:0]  cur, cur_next;
  logic [UNIT_W-1:0]  chk, chk_next;
  logic [UNIT_W-1:0]  last, last_next;
  logic [CNT_W-1:0]   run, run_next;
  logic [FRAG_W-1:0]  waste, waste_next;
  status_t            resp_status, resp_status_next;
  logic [UNIT_W-1:0]  resp_offset, resp_offset_next;

  logic               out_valid;
  status_t            out_status;
  logic [OFFSET_W-1:0] out_offset;
  logic [FRAG_W-1:0]  out_frag;

  mark_req_t          mreq;
  mark_t              rd_data;
  logic               clearing;

  logic               accept;
  logic               out_load;
  logic [BYTES_W:0]   round_sum;
  logic [CNT_W-1:0]   req_units;
  logic [CNT_W-1:0]   req_offset;
  logic [CNT_W-1:0]   run_inc;
  logic [CNT_W-1:0]   start_full;
  logic [PAD_W-1:0]   pad;
  logic [FRAG_W:0]    waste_sum;

  bffa_mark_store u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (mreq),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  assign req.ready  = (state == S_IDLE) && !clearing;
  assign accept     = req.valid && req.ready;
  assign out_load   = (state == S_RESP) && (!out_valid || rsp.ready);

  assign round_sum  = (BYTES_W + 1)'(req.request_bytes) + (BYTES_W + 1)'(UNIT_BYTES - 1);
  assign req_units  = CNT_W'(round_sum >> UNIT_SHIFT);
  assign req_offset = CNT_W'(req.block_offset);
  assign run_inc    = (rd_data == MARK_FREE) ? run + CNT_W'(1) : '0;
  assign start_full = CNT_W'(chk) + CNT_W'(1) - units;
  assign pad        = {units, UNIT_SHIFT'(0)} - PAD_W'(bytes);
  assign waste_sum  = {1'b0, waste} + (FRAG_W + 1)'(pad);

  always_comb begin
    state_next       = state;
    units_next       = units;
    bytes_next       = bytes;
    base_next        = base;
    cur_next         = cur;
    chk_next         = chk;
    last_next        = last;
    run_next         = run;
    waste_next       = waste;
    resp_status_next = resp_status;
    resp_offset_next = resp_offset;
    mreq.we          = 1'b0;
    mreq.waddr       = cur;
    mreq.wdata       = MARK_FREE;
    mreq.raddr       = '0;

    case (state)
      S_IDLE: begin
        mreq.raddr = (req.command == CMD_FREE) ? UNIT_W'(req_offset) : '0;
        if (accept) begin
          units_next       = req_units;
          bytes_next       = req.request_bytes;
          base_next        = UNIT_W'(req_offset);
          cur_next         = UNIT_W'(1);
          chk_next         = '0;
          run_next         = '0;
          resp_offset_next = '0;
          if (req.command == CMD_FREE) begin
            if (req_offset >= POOL_CNT) begin
              resp_status_next = ST_NOTHEAD;
              state_next       = S_RESP;
            end else begin
              state_next = S_FREE_CHECK;
            end
          end else if (req.request_bytes == '0 || req_units > POOL_CNT) begin
            resp_status_next = ST_NOSPACE;
            state_next       = S_RESP;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        mreq.raddr = cur;
        cur_next   = cur + UNIT_W'(1);
        run_next   = run_inc;
        chk_next   = chk + UNIT_W'(1);
        if (run_inc == units) begin
          base_next  = UNIT_W'(start_full);
          cur_next   = UNIT_W'(start_full);
          last_next  = chk;
          state_next = S_MARK;
        end else if (chk == LAST_UNIT) begin
          resp_status_next = ST_NOSPACE;
          state_next       = S_RESP;
        end
      end
      S_MARK: begin
        mreq.we    = 1'b1;
        mreq.waddr = cur;
        mreq.wdata = (cur == base) ? MARK_HEAD : MARK_CONT;
        cur_next   = cur + UNIT_W'(1);
        if (cur == last) begin
          waste_next       = waste_sum[FRAG_W] ? '1 : waste_sum[FRAG_W-1:0];
          resp_status_next = ST_OK;
          resp_offset_next = base;
          state_next       = S_RESP;
        end
      end
      S_FREE_CHECK: begin
        mreq.raddr = base + UNIT_W'(1);
        if (rd_data != MARK_HEAD) begin
          resp_status_next = ST_NOTHEAD;
          state_next       = S_RESP;
        end else begin
          mreq.we          = 1'b1;
          mreq.waddr       = base;
          resp_status_next = ST_OK;
          cur_next         = base + UNIT_W'(1);
          state_next       = (base == LAST_UNIT) ? S_RESP : S_FREE_WALK;
        end
      end
      S_FREE_WALK: begin
        mreq.raddr = cur + UNIT_W'(1);
        if (rd_data == MARK_CONT) begin
          mreq.we    = 1'b1;
          mreq.waddr = cur;
          cur_next   = cur + UNIT_W'(1);
          if (cur == LAST_UNIT) begin
            state_next = S_RESP;
          end
        end else begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      waste     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      waste <= waste_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    units       <= units_next;
    bytes       <= bytes_next;
    base        <= base_next;
    cur         <= cur_next;
    chk         <= chk_next;
    last        <= last_next;
    run         <= run_next;
    resp_status <= resp_status_next;
    resp_offset <= resp_offset_next;
    if (out_load) begin
      out_status <= resp_status;
      out_offset <= OFFSET_W'(resp_offset);
      out_frag   <= waste;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.granted_offset = out_offset;
  assign rsp.frag_total     = out_frag;

endmodule
